@@ hw/rtl/lcb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line comment blanker package
// Shared widths, register codes, word types and the length clamp function.
// ---------------------------------------------------------------------------
package lcb_pkg;

   localparam int ByteW     = 8;
   localparam int LenW      = 4;
   localparam int PatW      = 64;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 64;
   localparam int WindowDef = 8;

   localparam logic [ByteW-1:0] SpaceByte = 8'd32;

   // Register indexes on the configuration channel
   typedef enum logic [CsrIdxW-1:0] {
      CsrCommentPattern = 2'd0,
      CsrCommentLength  = 2'd1,
      CsrTermPattern    = 2'd2,
      CsrTermLength     = 2'd3
   } csr_idx_type;

   // One window cell: a byte of the stream and its end marker
   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             last;
      logic             valid;
   } slot_type;

   // Configuration register set
   typedef struct packed {
      logic [PatW-1:0] comment_pattern;
      logic [LenW-1:0] comment_length;
      logic [PatW-1:0] terminator_pattern;
      logic [LenW-1:0] terminator_length;
   } cfg_type;

   // Head decision towards the cell chain and output register
   typedef struct packed {
      logic             pop;
      logic [ByteW-1:0] out_byte;
      logic             out_last;
   } head_type;

   // Clamp a length register: zero counts as one, above the window as the window
   function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len,
                                                input logic [LenW-1:0] window);
      logic [LenW-1:0] res;
      res = len;
      if (len == '0) begin
         res = LenW'(1);
      end else if (len > window) begin
         res = window;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lcb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line comment blanker channels
// Byte input, byte output and configuration write channels.
// ---------------------------------------------------------------------------
interface lcb_req_if;
   import lcb_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] in_byte;
   logic             in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lcb_rsp_if;
   import lcb_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] out_byte;
   logic             out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface lcb_csr_if;
   import lcb_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lcb_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line comment blanker window cell
// Holds one byte of the lookahead window; takes its neighbour's byte when the
// head word leaves, or the incoming word when it is the first free cell.
// ---------------------------------------------------------------------------
module lcb_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic             push,
   input  lcb_pkg::slot_type in_slot,
   input  lcb_pkg::slot_type nxt_slot,
   input  logic             prev_valid_post,
   output lcb_pkg::slot_type slot,
   output logic             valid_post
);
   import lcb_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   logic [ByteW-1:0] data_ff;
   logic [ByteW-1:0] data_in;
   logic             last_ff;
   logic             last_in;
   logic             load;

   // Occupancy after this cycle's shift, and whether the new word lands here
   assign valid_post = shift ? nxt_slot.valid : valid_ff;
   assign load       = push && !valid_post && prev_valid_post;

   always_comb begin
      valid_in = valid_post;
      data_in  = data_ff;
      last_in  = last_ff;
      priority if (load) begin
         valid_in = in_slot.valid;
         data_in  = in_slot.data;
         last_in  = in_slot.last;
      end else if (shift) begin
         data_in  = nxt_slot.data;
         last_in  = nxt_slot.last;
      end
   end

   // Occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign slot = '{data: data_ff, last: last_ff, valid: valid_ff};

endmodule
`default_nettype wire

@@ hw/rtl/lcb_head.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line comment blanker head decision
// Compares the window against the terminator and comment strings, keeps the
// line state and decides the byte that leaves the head cell.
// ---------------------------------------------------------------------------
module lcb_head #(
   parameter int WINDOW = lcb_pkg::WindowDef
) (
   input  logic              clock,
   input  logic              reset,
   input  lcb_pkg::slot_type slot [WINDOW],
   input  lcb_pkg::cfg_type  cfg,
   input  logic              out_free,
   output lcb_pkg::head_type head
);
   import lcb_pkg::*;

   logic [LenW-1:0]   pass_ff;
   logic [LenW-1:0]   pass_in;
   logic              line_start_ff;
   logic              line_start_in;
   logic              comment_ff;
   logic              comment_in;

   logic [WINDOW-1:0] seg;
   logic              flush;
   logic [LenW-1:0]   tl;
   logic [LenW-1:0]   cl;
   logic              term_match;
   logic              comm_match;
   logic              term_enough;
   logic              comm_enough;
   logic              decide;
   logic [ByteW-1:0]  emit_byte;

   assign tl = eff_len(cfg.terminator_length, LenW'(WINDOW));
   assign cl = eff_len(cfg.comment_length, LenW'(WINDOW));

   // Mark the cells of the current buffer: up to and including the first end marker
   always_comb begin
      flush = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
         seg[i] = slot[i].valid && !flush;
         flush  = flush || (slot[i].valid && slot[i].last);
      end
   end

   // Parallel compare of both strings against the head of the window
   always_comb begin
      term_match  = 1'b1;
      comm_match  = 1'b1;
      term_enough = 1'b0;
      comm_enough = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
         if (LenW'(i) < tl) begin
            term_match = term_match &&
                         seg[i] && (slot[i].data == cfg.terminator_pattern[8*i +: 8]);
         end
         if (LenW'(i) < cl) begin
            comm_match = comm_match &&
                         seg[i] && (slot[i].data == cfg.comment_pattern[8*i +: 8]);
         end
         if (LenW'(i + 1) == tl) begin
            term_enough = seg[i];
         end
         if (LenW'(i + 1) == cl) begin
            comm_enough = seg[i];
         end
      end
   end

   // Decide the head byte; a terminator match takes priority over the comment
   always_comb begin
      decide        = 1'b0;
      emit_byte     = slot[0].data;
      pass_in       = pass_ff;
      line_start_in = line_start_ff;
      comment_in    = comment_ff;
      priority if (!seg[0]) begin
         decide = 1'b0;
      end else if (pass_ff != '0) begin
         decide        = 1'b1;
         pass_in       = pass_ff - LenW'(1);
         line_start_in = 1'b1;
      end else if (!flush && !term_enough) begin
         decide = 1'b0;
      end else if (term_match) begin
         decide        = 1'b1;
         pass_in       = tl - LenW'(1);
         line_start_in = 1'b1;
         comment_in    = 1'b0;
      end else if (comment_ff) begin
         decide    = 1'b1;
         emit_byte = SpaceByte;
      end else if (line_start_ff && !flush && !comm_enough) begin
         decide = 1'b0;
      end else if (line_start_ff && comm_match) begin
         decide     = 1'b1;
         emit_byte  = SpaceByte;
         comment_in = 1'b1;
      end else begin
         decide        = 1'b1;
         line_start_in = 1'b0;
      end
   end

   assign head = '{pop: decide && out_free, out_byte: emit_byte, out_last: slot[0].last};

   // Line state: advance on each byte leaving, back to line start after the last
   always_ff @(posedge clock) begin
      if (reset || (head.pop && slot[0].last)) begin
         pass_ff       <= '0;
         line_start_ff <= 1'b1;
         comment_ff    <= 1'b0;
      end else if (head.pop) begin
         pass_ff       <= pass_in;
         line_start_ff <= line_start_in;
         comment_ff    <= comment_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/line_comment_blanker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line comment blanker
// Passes a byte stream and overwrites lines that open with the comment string
// with spaces, up to but not including the line terminator.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch  : input words (in_byte, in_last); in_last marks the buffer end.
//   rsp_ch  : one output word per input word, same order; out_last on the
//             word of the final byte of a buffer.
//   csr_ch  : register writes (index, data), always ready; write only while
//             no byte is held inside the block.
// Throughput: one word per cycle in and out, window primed and rsp_ch ready.
// Decision: the head byte is decided once the window holds the terminator
//   length of bytes from it on (at a line start the comment length too, at
//   most WINDOW each) or the buffer end; it is then loaded into the output
//   register, from which rsp_ch presents it. A window of WINDOW cells shifts
//   towards the head as the head byte is decided.
// Reset: clears the window, line state and output register; registers go to
//   '#', 1, newline, 1.
// Stall: a stalled receiver holds the output word; input is still taken until
//   the window cells are all occupied.
// ---------------------------------------------------------------------------
module line_comment_blanker #(
   parameter int WINDOW = lcb_pkg::WindowDef
) (
   input  logic clock,
   input  logic reset,
   lcb_req_if.sink   req_ch,
   lcb_rsp_if.source rsp_ch,
   lcb_csr_if.sink   csr_ch
);
   import lcb_pkg::*;

   cfg_type          cfg_ff;
   slot_type         slot [WINDOW];
   slot_type         in_slot;
   logic [WINDOW-1:0] valid_post;
   head_type         head;
   logic             push;
   logic             out_free;
   logic             rsp_valid_ff;
   logic [ByteW-1:0] rsp_byte_ff;
   logic             rsp_last_ff;

   // Configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comment_pattern    <= PatW'(35);
         cfg_ff.comment_length     <= LenW'(1);
         cfg_ff.terminator_pattern <= PatW'(10);
         cfg_ff.terminator_length  <= LenW'(1);
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CsrCommentPattern: cfg_ff.comment_pattern    <= csr_ch.data;
            CsrCommentLength:  cfg_ff.comment_length     <= csr_ch.data[LenW-1:0];
            CsrTermPattern:    cfg_ff.terminator_pattern <= csr_ch.data;
            CsrTermLength:     cfg_ff.terminator_length  <= csr_ch.data[LenW-1:0];
            default: ;
         endcase
      end
   end

   // Input handshake: take a word while a cell is free or the head leaves
   assign req_ch.ready = !slot[WINDOW-1].valid || head.pop;
   assign push         = req_ch.valid && req_ch.ready;
   assign in_slot      = '{data: req_ch.in_byte, last: req_ch.in_last, valid: 1'b1};

   // Window cell chain
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      slot_type nxt;
      logic     prev_v;
      if (i == WINDOW - 1) begin : g_tail
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = slot[i+1];
      end
      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_rest
         assign prev_v = valid_post[i-1];
      end
      lcb_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .shift           (head.pop),
         .push            (push),
         .in_slot         (in_slot),
         .nxt_slot        (nxt),
         .prev_valid_post (prev_v),
         .slot            (slot[i]),
         .valid_post      (valid_post[i])
      );
   end

   // Head decision
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   lcb_head #(
      .WINDOW (WINDOW)
   ) u_head (
      .clock    (clock),
      .reset    (reset),
      .slot     (slot),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .head     (head)
   );

   // Output register: load on a decided byte, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head.pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head.pop) begin
         rsp_byte_ff <= head.out_byte;
         rsp_last_ff <= head.out_last;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.out_last = rsp_last_ff;

endmodule
`default_nettype wire
